// ===== hdl/wgm_pkg.sv =====
// Shared types, codes and helpers for the wildcard glob matcher.
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int MAX_LEN_DEF = 256;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_SUBJECT = 2'd1;
  localparam logic [1:0] CMD_EVAL    = 2'd2;

  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_STAR = 8'h2A;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pat;
    logic load_sub;
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ovf_seen;
    logic sub_done;
    logic is_star;
    logic lit_ok;
    logic have_star;
  } dp_stat_t;

  // Fold only 'A'..'Z' to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/wgm_dp.sv =====
// Datapath: pattern and subject stores, counts and the backtracking search registers.
`timescale 1ns / 1ps

module wgm_dp #(
  parameter int MAX_LEN = wgm_pkg::MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wgm_pkg::ctrl_cmd_t    cmd,
  input  logic [7:0]            in_byte,
  output wgm_pkg::dp_stat_t     stat,
  output logic                  out_matched,
  output logic                  out_overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE  = CW'(1);

  logic [7:0] pat_mem [MAX_LEN];
  logic [7:0] sub_mem [MAX_LEN];

  logic [CW-1:0] pcount_r, pcount_nxt;
  logic [CW-1:0] scount_r, scount_nxt;
  logic          ovf_seen_r, ovf_seen_nxt;
  logic [CW-1:0] pi_r, pi_nxt;
  logic [CW-1:0] si_r, si_nxt;
  logic [CW-1:0] back_p_r, back_p_nxt;
  logic [CW-1:0] back_s_r, back_s_nxt;
  logic          have_star_r, have_star_nxt;
  logic [7:0]    pdata_r;
  logic [7:0]    sdata_r;
  logic          matched_r;
  logic          overflow_r;

  logic p_valid;
  logic sub_done;
  logic pat_done;
  logic is_star;
  logic lit_ok;

  assign p_valid  = (pi_r < pcount_r);
  assign sub_done = (si_r == scount_r);
  assign pat_done = (pi_r == pcount_r);
  assign is_star  = p_valid && (pdata_r == wgm_pkg::CH_STAR);
  assign lit_ok   = p_valid && ((pdata_r == wgm_pkg::CH_ANY) ||
                    (wgm_pkg::fold_case(pdata_r) == wgm_pkg::fold_case(sdata_r)));

  assign stat.ovf_seen  = ovf_seen_r;
  assign stat.sub_done  = sub_done;
  assign stat.is_star   = is_star;
  assign stat.lit_ok    = lit_ok;
  assign stat.have_star = have_star_r;

  assign out_matched  = matched_r;
  assign out_overflow = overflow_r;

  always_comb begin
    pcount_nxt    = pcount_r;
    scount_nxt    = scount_r;
    ovf_seen_nxt  = ovf_seen_r;
    pi_nxt        = pi_r;
    si_nxt        = si_r;
    back_p_nxt    = back_p_r;
    back_s_nxt    = back_s_r;
    have_star_nxt = have_star_r;

    if (cmd.load_pat) begin
      if (pcount_r < FULL) begin
        pcount_nxt = pcount_r + ONE;
      end else begin
        ovf_seen_nxt = 1'b1;
      end
    end
    if (cmd.load_sub) begin
      if (scount_r < FULL) begin
        scount_nxt = scount_r + ONE;
      end else begin
        ovf_seen_nxt = 1'b1;
      end
    end
    if (cmd.start) begin
      pi_nxt        = '0;
      si_nxt        = '0;
      back_p_nxt    = '0;
      back_s_nxt    = '0;
      have_star_nxt = 1'b0;
    end
    if (cmd.step) begin
      if (!sub_done) begin
        if (is_star) begin
          // record the backtrack point and skip the star
          have_star_nxt = 1'b1;
          back_p_nxt    = pi_r;
          back_s_nxt    = si_r;
          pi_nxt        = pi_r + ONE;
        end else if (lit_ok) begin
          pi_nxt = pi_r + ONE;
          si_nxt = si_r + ONE;
        end else begin
          // let the last star swallow one more subject byte
          pi_nxt     = back_p_r + ONE;
          back_s_nxt = back_s_r + ONE;
          si_nxt     = back_s_r + ONE;
        end
      end else begin
        // trailing stars after the subject is used up
        pi_nxt = pi_r + ONE;
      end
    end
    if (cmd.finish) begin
      pcount_nxt   = '0;
      scount_nxt   = '0;
      ovf_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r   <= '0;
      scount_r   <= '0;
      ovf_seen_r <= 1'b0;
    end else begin
      pcount_r   <= pcount_nxt;
      scount_r   <= scount_nxt;
      ovf_seen_r <= ovf_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pi_r        <= pi_nxt;
    si_r        <= si_nxt;
    back_p_r    <= back_p_nxt;
    back_s_r    <= back_s_nxt;
    have_star_r <= have_star_nxt;
    if (cmd.finish) begin
      matched_r  <= !ovf_seen_r && sub_done && pat_done;
      overflow_r <= ovf_seen_r;
    end
  end

  // Stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.load_pat && (pcount_r < FULL)) begin
      pat_mem[pcount_r[AW-1:0]] <= in_byte;
    end
    pdata_r <= pat_mem[pi_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sub && (scount_r < FULL)) begin
      sub_mem[scount_r[AW-1:0]] <= in_byte;
    end
    sdata_r <= sub_mem[si_r[AW-1:0]];
  end

endmodule

// ===== hdl/wgm_ctrl.sv =====
// Controller: input handshake, search sequencing and result valid.
`timescale 1ns / 1ps

module wgm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_cmd,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  wgm_pkg::dp_stat_t   stat,
  output wgm_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       fail;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign fail = !stat.sub_done && !stat.is_star && !stat.lit_ok && !stat.have_star;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            wgm_pkg::CMD_PATTERN: cmd.load_pat = 1'b1;
            wgm_pkg::CMD_SUBJECT: cmd.load_sub = 1'b1;
            wgm_pkg::CMD_EVAL: begin
              if (stat.ovf_seen) begin
                // fail closed without searching
                cmd.finish    = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                cmd.start = 1'b1;
                state_nxt = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if ((stat.sub_done && !stat.is_star) || fail) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/wildcard_glob_matcher.sv =====
// Pattern and subject words are accepted back to back while no result word is stalled.
// Evaluate: each search step is a store read, then a compare; the final compare loads the
// result register. The greedy backtracking search takes up to about P*S steps for
// pattern length P and subject length S; input stalls during the search. Overflowed
// evaluates report next cycle.
// Reset (rst_n low, synchronous) empties both stores and clears overflow and valid.
`timescale 1ns / 1ps

module wildcard_glob_matcher #(
  parameter int MAX_LEN = wgm_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wgm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_byte
  input  logic [wgm_pkg::IN_TUSER_W-1:0]  in_tuser,   // [1:0] command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wgm_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] matched, [1] overflow, [7:2] zero
);

  wgm_pkg::ctrl_cmd_t cmd;
  wgm_pkg::dp_stat_t  stat;
  logic               matched;
  logic               overflow;

  wgm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wgm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_byte      (in_tdata),
    .stat         (stat),
    .out_matched  (matched),
    .out_overflow (overflow)
  );

  assign out_tdata = {6'b000000, overflow, matched};

endmodule

// ===== hdl/wgm_checker.sv =====
// Port-level checks for the wildcard glob matcher, bound to the top level.
`timescale 1ns / 1ps

module wgm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wgm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Overflow forces a no-match verdict.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("match reported with overflow");

  // Padding bits stay zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b000000)
    else $error("nonzero padding in result word");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Take no input word while a result word is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || out_tready)
    else $error("input accepted while result stalled");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
